FILE: hw/rtl/csfr_pkg.sv
// ----------------------------------------------------------------------------
// csfr_pkg
// Shared constants and types of the command and sensor frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package csfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int N_WORDS  = 8;
    localparam int WIDX_W   = $clog2(N_WORDS);
    localparam int POS_W    = 6;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;

    // Result item layout: mode, accepted, restart, then the eight words.
    localparam int OUT_HDR_W  = 4;
    localparam int OUT_BITS   = OUT_HDR_W + N_WORDS * WORD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Byte positions within a frame.
    localparam logic [POS_W-1:0] POS_FIRST_WORD = 6'd1;
    localparam logic [POS_W-1:0] POS_LAST_WORD  = 6'd32;
    localparam logic [POS_W-1:0] POS_CHECKSUM   = 6'd33;
    localparam logic [POS_W-1:0] POS_CMD_LAST   = 6'd4;
    localparam logic [POS_W-1:0] POS_DATA_LAST  = 6'd35;
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;

    localparam logic [MODE_W-1:0] MODE_NOMINAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PARKED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPLAY  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CMD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CMD_HEADER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DATA_HEADER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FOOTER_1    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FOOTER_2    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CODE_SIT    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CODE_REPLAY = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CODE_STOP   = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] command_header;
        logic [BYTE_W-1:0] data_header;
        logic [BYTE_W-1:0] footer_first;
        logic [BYTE_W-1:0] footer_second;
        logic [BYTE_W-1:0] code_sit;
        logic [BYTE_W-1:0] code_replay;
        logic [BYTE_W-1:0] code_stop;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        command_header: 8'd170,
        data_header:    8'd171,
        footer_first:   8'd13,
        footer_second:  8'd10,
        code_sit:       8'd1,
        code_replay:    8'd2,
        code_stop:      8'd3
    };

endpackage

`default_nettype wire

FILE: hw/rtl/csfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// csfr_cfg_regs
// Register bank of header, footer and command codes behind an APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module csfr_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csfr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [csfr_pkg::APB_DW-1:0]   pwdata,
    output logic      [csfr_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output csfr_pkg::cfg_t                     cfg
);

    csfr_pkg::cfg_t                           cfg_reg;
    csfr_pkg::cfg_t                           cfg_next;
    logic [csfr_pkg::REG_IDX_W-1:0]           reg_idx;
    logic [csfr_pkg::BYTE_W-1:0]              wbyte;
    logic [csfr_pkg::BYTE_W-1:0]              rbyte;
    logic                                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[csfr_pkg::APB_AW-1:2];
    assign wbyte   = pwdata[csfr_pkg::BYTE_W-1:0];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                csfr_pkg::REG_CMD_HEADER:  cfg_next.command_header = wbyte;
                csfr_pkg::REG_DATA_HEADER: cfg_next.data_header    = wbyte;
                csfr_pkg::REG_FOOTER_1:    cfg_next.footer_first   = wbyte;
                csfr_pkg::REG_FOOTER_2:    cfg_next.footer_second  = wbyte;
                csfr_pkg::REG_CODE_SIT:    cfg_next.code_sit       = wbyte;
                csfr_pkg::REG_CODE_REPLAY: cfg_next.code_replay    = wbyte;
                csfr_pkg::REG_CODE_STOP:   cfg_next.code_stop      = wbyte;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            csfr_pkg::REG_CMD_HEADER:  rbyte = cfg_reg.command_header;
            csfr_pkg::REG_DATA_HEADER: rbyte = cfg_reg.data_header;
            csfr_pkg::REG_FOOTER_1:    rbyte = cfg_reg.footer_first;
            csfr_pkg::REG_FOOTER_2:    rbyte = cfg_reg.footer_second;
            csfr_pkg::REG_CODE_SIT:    rbyte = cfg_reg.code_sit;
            csfr_pkg::REG_CODE_REPLAY: rbyte = cfg_reg.code_replay;
            csfr_pkg::REG_CODE_STOP:   rbyte = cfg_reg.code_stop;
            default:                   rbyte = '0;
        endcase
    end

    assign prdata = {{(csfr_pkg::APB_DW - csfr_pkg::BYTE_W){1'b0}}, rbyte};
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= csfr_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/command_and_sensor_frame_receiver.sv
// ----------------------------------------------------------------------------
// command_and_sensor_frame_receiver
// Parses command and sensor data frames from a byte stream, one result per
// frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; a result item is
// registered and shown in the cycle after the final byte of its frame is accepted.
// The input stalls only while a result waits in the output register and the
// sink is not ready; the frame checks are made combinationally on the final byte.
// Reset (synchronous, active low) restores the register defaults, normal
// mode, zero committed words and an empty output register.
`default_nettype none

module command_and_sensor_frame_receiver (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: rx_byte [7:0]
    input  wire logic [csfr_pkg::BYTE_W-1:0]       s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: mode [1:0], frame_accepted [2], fusion_restart [3],
    // altitude, pressure, accel x/y/z, gyro x/y/z words from [35:4] up
    // to [259:228], zero padding [263:260]
    output logic [csfr_pkg::OUT_DATA_W-1:0]        m_tdata,
    // m_tuser: frame_kind [1:0]
    output logic [csfr_pkg::KIND_W-1:0]            m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [csfr_pkg::APB_AW-1:0]       paddr,
    input  wire logic [csfr_pkg::APB_DW-1:0]       pwdata,
    output logic      [csfr_pkg::APB_DW-1:0]       prdata,
    output logic                                   pready
);

    csfr_pkg::cfg_t cfg;

    csfr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [csfr_pkg::POS_W-1:0]   pos_reg,      pos_next;
    logic [csfr_pkg::BYTE_W-1:0]  sum_reg,      sum_next;
    logic [csfr_pkg::BYTE_W-1:0]  first_reg,    first_next;
    logic [csfr_pkg::BYTE_W-1:0]  cmd_reg,      cmd_next;
    logic [csfr_pkg::BYTE_W-1:0]  chk_reg,      chk_next;
    logic [csfr_pkg::BYTE_W-1:0]  prev_reg,     prev_next;
    logic [csfr_pkg::MODE_W-1:0]  mode_reg,     mode_next;
    logic [csfr_pkg::KIND_W-1:0]  kind_reg,     kind_next;
    logic                         acc_reg,      acc_next;
    logic                         restart_reg,  restart_next;
    logic                         m_valid_reg,  m_valid_next;

    logic [csfr_pkg::WORD_W-1:0]  staging_words_reg   [csfr_pkg::N_WORDS];
    logic [csfr_pkg::WORD_W-1:0]  committed_words_reg [csfr_pkg::N_WORDS];

    logic                         in_fire;
    logic                         eof_fire;
    logic                         commit;
    logic                         footers_ok;
    logic                         stage_wr;
    logic [csfr_pkg::POS_W-1:0]   stage_off;
    logic [csfr_pkg::WIDX_W-1:0]  stage_idx;
    logic [1:0]                   stage_lane;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign eof_fire = in_fire && s_tlast;

    assign stage_wr   = in_fire && (pos_reg >= csfr_pkg::POS_FIRST_WORD)
                        && (pos_reg <= csfr_pkg::POS_LAST_WORD);
    assign stage_off  = pos_reg - csfr_pkg::POS_FIRST_WORD;
    assign stage_idx  = stage_off[csfr_pkg::WIDX_W+1:2];
    assign stage_lane = stage_off[1:0];

    assign footers_ok = (prev_reg == cfg.footer_first) && (s_tdata == cfg.footer_second);

    always_comb begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        first_next   = first_reg;
        cmd_next     = cmd_reg;
        chk_next     = chk_reg;
        prev_next    = prev_reg;
        mode_next    = mode_reg;
        kind_next    = kind_reg;
        acc_next     = acc_reg;
        restart_next = restart_reg;
        m_valid_next = m_valid_reg && !m_tready;
        commit       = 1'b0;

        if (in_fire) begin
            prev_next = s_tdata;
            if (pos_reg == '0) begin
                first_next = s_tdata;
            end
            if (pos_reg == csfr_pkg::POS_FIRST_WORD) begin
                cmd_next = s_tdata;
            end
            if (pos_reg == csfr_pkg::POS_CHECKSUM) begin
                chk_next = s_tdata;
            end
            if (pos_reg < csfr_pkg::POS_CHECKSUM) begin
                sum_next = sum_reg + s_tdata;
            end

            if (!s_tlast) begin
                if (pos_reg != csfr_pkg::POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
            end else begin
                pos_next     = '0;
                sum_next     = '0;
                kind_next    = csfr_pkg::KIND_NONE;
                acc_next     = 1'b0;
                restart_next = 1'b0;
                m_valid_next = 1'b1;
                if ((first_reg == cfg.command_header)
                        && (pos_reg == csfr_pkg::POS_CMD_LAST)) begin
                    kind_next = csfr_pkg::KIND_CMD;
                    if (footers_ok) begin
                        acc_next = 1'b1;
                        if (cmd_reg == cfg.code_sit) begin
                            mode_next = csfr_pkg::MODE_PARKED;
                        end else if (cmd_reg == cfg.code_replay) begin
                            mode_next    = csfr_pkg::MODE_REPLAY;
                            restart_next = 1'b1;
                        end else if (cmd_reg == cfg.code_stop) begin
                            mode_next = csfr_pkg::MODE_NOMINAL;
                        end
                    end
                end else if ((first_reg == cfg.data_header)
                        && (pos_reg == csfr_pkg::POS_DATA_LAST)) begin
                    kind_next = csfr_pkg::KIND_DATA;
                    if (footers_ok && (sum_reg == chk_reg)) begin
                        acc_next = 1'b1;
                        commit   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            first_reg   <= '0;
            cmd_reg     <= '0;
            chk_reg     <= '0;
            prev_reg    <= '0;
            mode_reg    <= csfr_pkg::MODE_NOMINAL;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            first_reg   <= first_next;
            cmd_reg     <= cmd_next;
            chk_reg     <= chk_next;
            prev_reg    <= prev_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        acc_reg     <= acc_next;
        restart_reg <= restart_next;
    end

    always_ff @(posedge aclk) begin
        if (stage_wr) begin
            staging_words_reg[stage_idx][{stage_lane, 3'b000} +: csfr_pkg::BYTE_W] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < csfr_pkg::N_WORDS; i++) begin
                committed_words_reg[i] <= '0;
            end
        end else if (commit) begin
            for (int i = 0; i < csfr_pkg::N_WORDS; i++) begin
                committed_words_reg[i] <= staging_words_reg[i];
            end
        end
    end

    always_comb begin
        m_tdata        = '0;
        m_tdata[1:0]   = mode_reg;
        m_tdata[2]     = acc_reg;
        m_tdata[3]     = restart_reg;
        for (int i = 0; i < csfr_pkg::N_WORDS; i++) begin
            m_tdata[csfr_pkg::OUT_HDR_W + i*csfr_pkg::WORD_W +: csfr_pkg::WORD_W] =
                committed_words_reg[i];
        end
    end

    assign m_tuser  = kind_reg;
    assign m_tvalid = m_valid_reg;

    a_restart_means_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && restart_reg |-> acc_reg && (mode_reg == csfr_pkg::MODE_REPLAY)
                                       && (kind_reg == csfr_pkg::KIND_CMD))
        else $error("fusion restart without an accepted replay command");

    a_accept_has_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && acc_reg |-> (kind_reg != csfr_pkg::KIND_NONE))
        else $error("accepted frame reported as unrecognized");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while a result is stalled");

    a_eof_restarts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        eof_fire |=> (pos_reg == '0) && (sum_reg == '0) && m_valid_reg)
        else $error("frame state not restarted after the final byte");

endmodule

`default_nettype wire

FILE: dv/csfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfr_frame_checker
// Follows the byte stream, the result stream and the register port of the
// frame receiver, keeps its own copy of the parser state and the registers,
// and compares every result item, and every read of the seven registers, with what it expects.
// ----------------------------------------------------------------------------

module csfr_frame_checker
    import csfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [BYTE_W-1:0]     s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [KIND_W-1:0]     m_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    input  wire logic [APB_DW-1:0]     prdata,
    input  wire logic                  pready,
    input  wire logic                  end_of_test,
    output int                         error_count,
    output int                         results_pending
);

    typedef struct packed {
        logic [MODE_W-1:0]                mode;
        logic [KIND_W-1:0]                kind;
        logic                             accepted;
        logic                             restart;
        logic [N_WORDS-1:0][WORD_W-1:0]   words;
    } frame_result_t;

    frame_result_t                  pending_frames[$];
    cfg_t                           regs;
    logic [POS_W-1:0]               byte_pos;
    logic [BYTE_W-1:0]              frame_sum;
    logic [BYTE_W-1:0]              first_b;
    logic [BYTE_W-1:0]              cmd_b;
    logic [BYTE_W-1:0]              chk_b;
    logic [BYTE_W-1:0]              prev_b;
    logic [MODE_W-1:0]              cur_mode;
    logic [N_WORDS-1:0][WORD_W-1:0] staging;
    logic [N_WORDS-1:0][WORD_W-1:0] committed;
    int                             errors = 0;
    bit                             leftovers_checked;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        errors++;
    endtask

    function automatic logic [BYTE_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_CMD_HEADER:  return regs.command_header;
            REG_DATA_HEADER: return regs.data_header;
            REG_FOOTER_1:    return regs.footer_first;
            REG_FOOTER_2:    return regs.footer_second;
            REG_CODE_SIT:    return regs.code_sit;
            REG_CODE_REPLAY: return regs.code_replay;
            default:         return regs.code_stop;
        endcase
    endfunction

    task automatic track_register_port();
        logic [REG_IDX_W-1:0] idx;
        idx = paddr[APB_AW-1:2];
        if (psel && penable && pready) begin
            if (pwrite) begin
                case (idx)
                    REG_CMD_HEADER:  regs.command_header = pwdata[BYTE_W-1:0];
                    REG_DATA_HEADER: regs.data_header    = pwdata[BYTE_W-1:0];
                    REG_FOOTER_1:    regs.footer_first   = pwdata[BYTE_W-1:0];
                    REG_FOOTER_2:    regs.footer_second  = pwdata[BYTE_W-1:0];
                    REG_CODE_SIT:    regs.code_sit       = pwdata[BYTE_W-1:0];
                    REG_CODE_REPLAY: regs.code_replay    = pwdata[BYTE_W-1:0];
                    REG_CODE_STOP:   regs.code_stop      = pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end else if (idx <= REG_CODE_STOP) begin
                if (prdata != APB_DW'(reg_value(idx)))
                    report_mismatch($sformatf("register %0d read", idx),
                                    APB_DW'(reg_value(idx)), prdata);
            end
        end
    endtask

    task automatic track_rx_byte(input logic [BYTE_W-1:0] b, input logic eof);
        logic [POS_W-1:0] pos;
        logic             footers_ok;
        frame_result_t    r;
        int               widx;
        int               boff;
        pos = byte_pos;
        if (pos == '0) first_b = b;
        if (pos == POS_FIRST_WORD) cmd_b = b;
        if (pos == POS_CHECKSUM) chk_b = b;
        if (pos < POS_CHECKSUM) frame_sum = frame_sum + b;
        if (pos >= POS_FIRST_WORD && pos <= POS_LAST_WORD) begin
            widx = (int'(pos) - 1) / 4;
            boff = ((int'(pos) - 1) % 4) * BYTE_W;
            staging[widx][boff +: BYTE_W] = b;
        end
        if (!eof) begin
            prev_b = b;
            if (pos < POS_MAX) byte_pos = pos + 1'b1;
        end else begin
            r = '0;
            r.kind = KIND_NONE;
            footers_ok = (prev_b == regs.footer_first) && (b == regs.footer_second);
            if (first_b == regs.command_header && pos == POS_CMD_LAST) begin
                r.kind = KIND_CMD;
                if (footers_ok) begin
                    r.accepted = 1'b1;
                    if (cmd_b == regs.code_sit) begin
                        cur_mode = MODE_PARKED;
                    end else if (cmd_b == regs.code_replay) begin
                        cur_mode = MODE_REPLAY;
                        r.restart = 1'b1;
                    end else if (cmd_b == regs.code_stop) begin
                        cur_mode = MODE_NOMINAL;
                    end
                end
            end else if (first_b == regs.data_header && pos == POS_DATA_LAST) begin
                r.kind = KIND_DATA;
                if (footers_ok && frame_sum == chk_b) begin
                    r.accepted = 1'b1;
                    committed = staging;
                end
            end
            r.mode = cur_mode;
            r.words = committed;
            pending_frames.push_back(r);
            prev_b = b;
            byte_pos = '0;
            frame_sum = '0;
        end
    endtask

    task automatic check_frame_result();
        frame_result_t want;
        if (pending_frames.size() == 0) begin
            report_mismatch("result item with no frame pending", '0, WORD_W'(m_tuser));
        end else begin
            want = pending_frames.pop_front();
            if (m_tdata[MODE_W-1:0] != want.mode)
                report_mismatch("mode", WORD_W'(want.mode), WORD_W'(m_tdata[MODE_W-1:0]));
            if (m_tuser != want.kind)
                report_mismatch("frame_kind", WORD_W'(want.kind), WORD_W'(m_tuser));
            if (m_tdata[2] != want.accepted)
                report_mismatch("frame_accepted", WORD_W'(want.accepted),
                                WORD_W'(m_tdata[2]));
            if (m_tdata[3] != want.restart)
                report_mismatch("fusion_restart", WORD_W'(want.restart),
                                WORD_W'(m_tdata[3]));
            for (int i = 0; i < N_WORDS; i++) begin
                if (m_tdata[OUT_HDR_W + WORD_W*i +: WORD_W] != want.words[i])
                    report_mismatch($sformatf("sensor word %0d", i), want.words[i],
                                    m_tdata[OUT_HDR_W + WORD_W*i +: WORD_W]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs = CFG_RESET;
            byte_pos = '0;
            frame_sum = '0;
            first_b = '0;
            cmd_b = '0;
            chk_b = '0;
            prev_b = '0;
            cur_mode = MODE_NOMINAL;
            staging = '0;
            committed = '0;
            pending_frames.delete();
            leftovers_checked = 1'b0;
        end else begin
            track_register_port();
            if (m_tvalid && m_tready) check_frame_result();
            if (s_tvalid && s_tready) track_rx_byte(s_tdata, s_tlast);
            if (end_of_test && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (pending_frames.size() != 0)
                    report_mismatch("frames without a result", '0, pending_frames.size());
            end
        end
        error_count <= errors;
        results_pending <= pending_frames.size();
    end

endmodule

FILE: dv/command_and_sensor_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_and_sensor_frame_receiver_tb
// Feeds the frame receiver with command frames, sensor data frames, broken
// frames and line noise under several register settings, with random gaps
// on the byte stream and random back-pressure on the results. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module command_and_sensor_frame_receiver_tb;
    import csfr_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_BYTES  = 84;
    localparam int N_PHASES     = 5;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef logic [BYTE_W-1:0] byte_q_t[$];
    typedef enum int {FLAW_NONE, FLAW_FOOTER_1, FLAW_FOOTER_2, FLAW_CHECKSUM,
                      FLAW_SHORT, FLAW_LONG} flaw_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  end_of_test = 1'b0;
    int                    error_count;
    int                    results_pending;

    bit   src_idle_on = 1'b1;
    bit   snk_idle_on = 1'b1;
    int   snk_hold = 0;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   phase_base = 0;
    cfg_t tb_cfg = CFG_RESET;

    command_and_sensor_frame_receiver DUT (.*);

    csfr_frame_checker checker_i (.*);

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("command_and_sensor_frame_receiver_tb: errors");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (snk_hold != 0) begin
            snk_hold <= snk_hold - 1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
            snk_hold <= $urandom_range(0, 6);
        end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            snk_hold <= idle_length() - 1;
        end
    end

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [BYTE_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_back_regs();
        for (int i = REG_CMD_HEADER; i <= REG_CODE_STOP; i++)
            apb_access(1'b0, REG_IDX_W'(i), '0);
    endtask

    task automatic load_regs(input cfg_t c);
        apb_access(1'b1, REG_CMD_HEADER, c.command_header);
        apb_access(1'b1, REG_DATA_HEADER, c.data_header);
        apb_access(1'b1, REG_FOOTER_1, c.footer_first);
        apb_access(1'b1, REG_FOOTER_2, c.footer_second);
        apb_access(1'b1, REG_CODE_SIT, c.code_sit);
        apb_access(1'b1, REG_CODE_REPLAY, c.code_replay);
        apb_access(1'b1, REG_CODE_STOP, c.code_stop);
        apb_access(1'b1, REG_UNUSED, 8'($urandom));
        tb_cfg = c;
        read_back_regs();
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t f);
        for (int i = 0; i < f.size(); i++)
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic byte_q_t command_frame(input logic [BYTE_W-1:0] hdr,
                                              input logic [BYTE_W-1:0] code,
                                              input flaw_t flaw);
        byte_q_t f;
        f = '{hdr, code, 8'($urandom), tb_cfg.footer_first, tb_cfg.footer_second};
        case (flaw)
            FLAW_FOOTER_1: f[3] ^= 8'($urandom_range(1, 255));
            FLAW_FOOTER_2: f[4] ^= 8'($urandom_range(1, 255));
            FLAW_SHORT:    f.delete(2);
            FLAW_LONG:     f.insert(2, 8'($urandom));
            default: ;
        endcase
        return f;
    endfunction

    function automatic byte_q_t data_frame(input logic [BYTE_W-1:0] hdr, input fill_t fill,
                                           input flaw_t flaw);
        byte_q_t           f;
        logic [BYTE_W-1:0] sum;
        logic [WORD_W-1:0] w;
        f.push_back(hdr);
        sum = hdr;
        for (int i = 0; i < N_WORDS; i++) begin
            w = (fill == FILL_RANDOM) ? $urandom : (fill == FILL_ZERO) ? '0 : '1;
            for (int k = 0; k < 4; k++) begin
                f.push_back(w[BYTE_W*k +: BYTE_W]);
                sum = sum + w[BYTE_W*k +: BYTE_W];
            end
        end
        if (flaw == FLAW_CHECKSUM) sum = sum + 8'($urandom_range(1, 255));
        f.push_back(sum);
        f.push_back(tb_cfg.footer_first);
        f.push_back(tb_cfg.footer_second);
        case (flaw)
            FLAW_FOOTER_1: f[34] ^= 8'($urandom_range(1, 255));
            FLAW_FOOTER_2: f[35] ^= 8'($urandom_range(1, 255));
            FLAW_SHORT:    f.delete(5);
            FLAW_LONG:     f.insert(5, 8'($urandom));
            default: ;
        endcase
        return f;
    endfunction

    function automatic byte_q_t noise_frame(input int len, input logic [BYTE_W-1:0] first);
        byte_q_t f;
        f.push_back(first);
        for (int i = 1; i < len; i++) f.push_back(8'($urandom));
        return f;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return tb_cfg.code_sit;
            1:       return tb_cfg.code_replay;
            2:       return tb_cfg.code_stop;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_first();
        case ($urandom_range(0, 2))
            0:       return tb_cfg.command_header;
            1:       return tb_cfg.data_header;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) src_idle_on = !src_idle_on;
        if ($urandom_range(0, 15) == 0) snk_idle_on <= !snk_idle_on;
        if (pick < 35)
            send_frame(command_frame(tb_cfg.command_header, pick_code(), FLAW_NONE));
        else if (pick < 60)
            send_frame(data_frame(tb_cfg.data_header, FILL_RANDOM, FLAW_NONE));
        else if (pick < 70)
            send_frame(command_frame(tb_cfg.command_header, pick_code(),
                                     flaw_t'($urandom_range(FLAW_FOOTER_1, FLAW_LONG))));
        else if (pick < 80)
            send_frame(data_frame(tb_cfg.data_header, FILL_RANDOM,
                                  flaw_t'($urandom_range(FLAW_FOOTER_1, FLAW_LONG))));
        else if (pick < 96)
            send_frame(noise_frame($urandom_range(1, 40), pick_first()));
        else
            send_frame(noise_frame($urandom_range(60, 70), pick_first()));
    endtask

    function automatic cfg_t phase_regs(input int p);
        cfg_t c;
        case (p)
            1: c = '0;
            2: c = '1;
            3: begin
                c.command_header = 8'($urandom);
                c.data_header    = 8'($urandom);
                c.footer_first   = 8'($urandom);
                c.footer_second  = 8'($urandom);
                c.code_sit       = 8'($urandom);
                c.code_replay    = 8'($urandom);
                c.code_stop      = 8'($urandom);
            end
            default: begin
                c.command_header = 8'h5A;
                c.data_header    = 8'h5A;
                c.footer_first   = 8'($urandom);
                c.footer_second  = 8'($urandom);
                c.code_sit       = 8'h20;
                c.code_replay    = 8'h10;
                c.code_stop      = 8'h10;
            end
        endcase
        return c;
    endfunction

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_back_regs();

        send_frame(command_frame(tb_cfg.command_header, tb_cfg.code_sit, FLAW_NONE));
        send_frame(command_frame(tb_cfg.command_header, tb_cfg.code_replay, FLAW_NONE));
        send_frame(command_frame(tb_cfg.command_header, 8'hFF, FLAW_NONE));
        send_frame(command_frame(tb_cfg.command_header, tb_cfg.code_stop, FLAW_NONE));
        send_frame(command_frame(tb_cfg.command_header, tb_cfg.code_sit, FLAW_FOOTER_2));
        send_frame(command_frame(tb_cfg.command_header, tb_cfg.code_sit, FLAW_SHORT));
        send_frame(data_frame(tb_cfg.data_header, FILL_ONES, FLAW_NONE));
        send_frame(data_frame(tb_cfg.data_header, FILL_ZERO, FLAW_CHECKSUM));
        send_frame(data_frame(tb_cfg.data_header, FILL_RANDOM, FLAW_FOOTER_1));
        send_frame(data_frame(tb_cfg.data_header, FILL_ZERO, FLAW_NONE));
        send_frame(data_frame(tb_cfg.data_header, FILL_RANDOM, FLAW_LONG));
        send_frame(noise_frame(1, 8'h00));
        send_frame(noise_frame(5, 8'h55));
        send_frame(noise_frame(64, tb_cfg.data_header));

        phase_base = bytes_sent;
        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                wait_for_results();
                load_regs(phase_regs(p));
            end
            while (bytes_sent < phase_base + (p + 1) * PHASE_BYTES) send_random_frame();
        end

        wait_for_results();
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        if (error_count == 0) begin
            $display("command_and_sensor_frame_receiver_tb: clean");
        end else begin
            $display("command_and_sensor_frame_receiver_tb: errors");
        end
        $finish;
    end

endmodule

FILE: command_and_sensor_frame_receiver.f
hw/rtl/csfr_pkg.sv
hw/rtl/csfr_cfg_regs.sv
hw/rtl/command_and_sensor_frame_receiver.sv
dv/csfr_frame_checker.sv
dv/command_and_sensor_frame_receiver_tb.sv
